FILE: rtl/core/affine_point_transform_assert.svh
// Assertion macros used by the point transform top level.
`ifndef AFFINE_POINT_TRANSFORM_ASSERT_SVH
`define AFFINE_POINT_TRANSFORM_ASSERT_SVH

// An implication checked on every rising clock edge outside reset.
`define APT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// An implication whose consequent is checked in the cycle after the antecedent.
`define APT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/apt_pkg.sv
`default_nettype none

package apt_pkg;

    localparam int unsigned FloatWidth = 32;
    localparam int unsigned NumRegs    = 6;
    localparam int unsigned CfgWidth   = 64;
    localparam int unsigned IdxWidth   = 3;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    localparam logic [CfgWidth-1:0] RESET_R0A = 64'h0000_0000_3F80_0000;
    localparam logic [CfgWidth-1:0] RESET_R0B = 64'h0;
    localparam logic [CfgWidth-1:0] RESET_R1A = 64'h3F80_0000_0000_0000;
    localparam logic [CfgWidth-1:0] RESET_R1B = 64'h0;
    localparam logic [CfgWidth-1:0] RESET_R2A = 64'h0;
    localparam logic [CfgWidth-1:0] RESET_R2B = 64'h0000_0000_3F80_0000;

    // Register indexes.
    localparam logic [IdxWidth-1:0] REG_R0A = 3'd0;
    localparam logic [IdxWidth-1:0] REG_R0B = 3'd1;
    localparam logic [IdxWidth-1:0] REG_R1A = 3'd2;
    localparam logic [IdxWidth-1:0] REG_R1B = 3'd3;
    localparam logic [IdxWidth-1:0] REG_R2A = 3'd4;
    localparam logic [IdxWidth-1:0] REG_R2B = 3'd5;

    // Unpacked operand: class flags, sign, exponent of the lsb and significand.
    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        zero;
        logic        sign;
        logic [9:0]  exp;   // signed exponent of significand lsb
        logic [23:0] sig;
    } fp_unp_t;

    // Value before rounding: sig * 2^exp, with class flags.
    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        zero;
        logic        sign;
        logic [9:0]  exp;
        logic [49:0] sig;
    } fp_raw_t;

    function automatic fp_unp_t fp_unpack(input logic [31:0] v);
        fp_unp_t u;
        u.nan  = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
        u.inf  = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
        u.zero = (v[30:0] == 31'd0);
        u.sign = v[31];
        if (v[30:23] == 8'd0)
        begin
            u.sig = {1'b0, v[22:0]};
            u.exp = -10'sd149;
        end
        else
        begin
            u.sig = {1'b1, v[22:0]};
            u.exp = 10'({2'b00, v[30:23]}) - 10'd150;
        end
        return u;
    endfunction

    // Leading one position of a 50 bit word.
    function automatic logic [5:0] lead_one(input logic [49:0] s);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 50; i++)
        begin
            if (s[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    // Round sig * 2^exp to binary32, nearest even; sig is nonzero.
    function automatic logic [31:0] fp_round(input logic sign, input logic [9:0] exp,
                                             input logic [49:0] sig);
        logic signed [11:0] e;
        logic signed [11:0] sh;
        logic signed [11:0] shmin;
        logic [5:0]         p;
        logic [49:0]        q;
        logic [49:0]        rem;
        logic [49:0]        half;
        logic [49:0]        mask;
        logic               sticky;
        logic [31:0]        r;
        e      = 12'(signed'(exp));
        p      = lead_one(sig);
        sh     = 12'(p) - 12'sd23;
        shmin  = -12'sd149 - e;
        sticky = 1'b0;
        if (shmin > sh)
        begin
            sh = shmin;
        end
        if (sh <= 0)
        begin
            q = sig << 6'(-sh);
        end
        else
        begin
            if (sh > 12'sd50)
            begin
                sticky = 1'b1;
                q      = 50'd0;
                rem    = 50'd1;
                half   = 50'd2;
            end
            else
            begin
                mask = (50'd1 << 6'(sh)) - 50'd1;
                q    = sig >> 6'(sh);
                rem  = sig & mask;
                half = 50'd1 << 6'(sh - 12'sd1);
            end
            // Beyond 50 the whole word lies below the half point.
            if (!sticky && ((rem > half) || ((rem == half) && q[0])))
            begin
                q = q + 50'd1;
            end
        end
        e = e + sh;
        if (q[24])
        begin
            q = q >> 1;
            e = e + 12'sd1;
        end
        if (q < 50'h80_0000)
        begin
            r = {sign, 31'(q)};
        end
        else if (e + 12'sd150 >= 12'sd255)
        begin
            r = {sign, 8'hFF, 23'd0};
        end
        else
        begin
            r = {sign, 8'(e + 12'sd150), q[22:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/affine_point_transform.sv
`default_nettype none

`include "affine_point_transform_assert.svh"

// Affine point transform in IEEE binary32: each item (x, y, z) gives
// ((m_r0*x + m_r1*y) + m_r2*z) + m_r3 per row, every operation rounded to
// nearest even, any NaN returned as 0x7FC00000. One item is accepted per
// cycle while no result waits untaken; each result comes out of the chain
// of a multiplier and three adders of three stages each. The whole
// pipeline advances together and halts, input included, while a result
// waits untaken; such a wait holds back every item in flight. Reset loads
// the identity.
module affine_point_transform
    import apt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [IdxWidth-1:0] cfg_index,
    input  wire logic [CfgWidth-1:0] cfg_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [95:0]         s_tdata,   // x_in, y_in, z_in
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [95:0]         m_tdata    // x_out, y_out, z_out
);

    localparam int unsigned Depth = 12;

    logic [CfgWidth-1:0] cfg_reg [NumRegs];
    logic [Depth-1:0]    vld_reg;
    logic [31:0]         zp_dl_reg [3][3];
    logic [31:0]         off_dl_reg [3][9];
    logic                en;
    logic [31:0]         prod [3][3];
    logic [31:0]         s1 [3];
    logic [31:0]         s2 [3];
    logic [31:0]         s3 [3];

    // The pipe moves when the output slot is empty or being drained.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[Depth-1];
    assign m_tdata  = {s3[2], s3[1], s3[0]};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0] <= RESET_R0A;
            cfg_reg[1] <= RESET_R0B;
            cfg_reg[2] <= RESET_R1A;
            cfg_reg[3] <= RESET_R1B;
            cfg_reg[4] <= RESET_R2A;
            cfg_reg[5] <= RESET_R2B;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_R0A: cfg_reg[0] <= cfg_data;
                REG_R0B: cfg_reg[1] <= cfg_data;
                REG_R1A: cfg_reg[2] <= cfg_data;
                REG_R1B: cfg_reg[3] <= cfg_data;
                REG_R2A: cfg_reg[4] <= cfg_data;
                REG_R2B: cfg_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits travelling with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Depth-2:0], s_tvalid};
        end
    end

    // Delay lines for z products and offsets to meet the adder chain.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                zp_dl_reg[r][0] <= prod[r][2];
                zp_dl_reg[r][1] <= zp_dl_reg[r][0];
                zp_dl_reg[r][2] <= zp_dl_reg[r][1];
                off_dl_reg[r][0] <= cfg_reg[2*r+1][63:32];
                for (int k = 1; k < 9; k++)
                begin
                    off_dl_reg[r][k] <= off_dl_reg[r][k-1];
                end
            end
        end
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        apt_fmul u_mx (.clk, .en, .a(cfg_reg[2*r][31:0]),  .b(s_tdata[31:0]),  .p(prod[r][0]));
        apt_fmul u_my (.clk, .en, .a(cfg_reg[2*r][63:32]), .b(s_tdata[63:32]), .p(prod[r][1]));
        apt_fmul u_mz (.clk, .en, .a(cfg_reg[2*r+1][31:0]), .b(s_tdata[95:64]),
                       .p(prod[r][2]));
        apt_fadd u_a1 (.clk, .en, .a(prod[r][0]), .b(prod[r][1]), .s(s1[r]));
        apt_fadd u_a2 (.clk, .en, .a(s1[r]), .b(zp_dl_reg[r][2]), .s(s2[r]));
        apt_fadd u_a3 (.clk, .en, .a(s2[r]), .b(off_dl_reg[r][8]), .s(s3[r]));
    end

    // Handshake rules on the result side.
    `APT_ASSERT_IMP(a_ready_rule, clk, rst_n, 1'b1, s_tready == (!m_tvalid || m_tready))
    `APT_ASSERT_NEXT(a_valid_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `APT_ASSERT_NEXT(a_data_hold, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

`default_nettype wire

FILE: rtl/core/apt_fmul.sv
`default_nettype none

// Three-stage binary32 multiplier: unpack, multiply, round.
module apt_fmul
    import apt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] p
);

    fp_unp_t     ua_reg, ub_reg;
    fp_raw_t     raw_reg;
    logic [31:0] p_reg;
    logic [31:0] p_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg <= fp_unpack(a);
            ub_reg <= fp_unpack(b);
            raw_reg.nan  <= ua_reg.nan || ub_reg.nan ||
                            (ua_reg.inf && ub_reg.zero) || (ub_reg.inf && ua_reg.zero);
            raw_reg.inf  <= ua_reg.inf || ub_reg.inf;
            raw_reg.zero <= ua_reg.zero || ub_reg.zero;
            raw_reg.sign <= ua_reg.sign ^ ub_reg.sign;
            raw_reg.exp  <= ua_reg.exp + ub_reg.exp;
            raw_reg.sig  <= {2'b00, 48'(ua_reg.sig * ub_reg.sig)};
            p_reg <= p_next;
        end
    end

    // Final rounding and special-case selection.
    always_comb
    begin
        if (raw_reg.nan)
        begin
            p_next = QNAN;
        end
        else if (raw_reg.inf)
        begin
            p_next = {raw_reg.sign, 8'hFF, 23'd0};
        end
        else if (raw_reg.zero)
        begin
            p_next = {raw_reg.sign, 31'd0};
        end
        else
        begin
            p_next = fp_round(raw_reg.sign, raw_reg.exp, raw_reg.sig);
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

FILE: rtl/core/apt_fadd.sv
`default_nettype none

// Three-stage binary32 adder: unpack and order, align and add, round.
module apt_fadd
    import apt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] s
);

    fp_unp_t     big_reg, small_reg;
    logic        spec_reg;
    logic [31:0] spec_val_reg;
    logic        spec2_reg;
    logic [31:0] spec2_val_reg;
    logic        cancel_reg;
    fp_raw_t     raw_reg;
    logic [31:0] s_reg;

    fp_unp_t     ua, ub;
    logic        swap;
    logic        spec_next;
    logic [31:0] spec_val_next;
    logic [9:0]  d;
    logic [49:0] bigs, smls, smlsh, sum;
    logic        st;
    logic [31:0] s_next;

    // Special operands and ordering by magnitude.
    always_comb
    begin
        ua = fp_unpack(a);
        ub = fp_unpack(b);
        swap = (ua.exp < ub.exp && ua.exp[9] == ub.exp[9]) ||
               (ua.exp[9] && !ub.exp[9]) ||
               (ua.exp == ub.exp && ua.sig < ub.sig);
        spec_next = 1'b1;
        spec_val_next = 32'd0;
        if (ua.nan || ub.nan)
        begin
            spec_val_next = QNAN;
        end
        else if (ua.inf)
        begin
            spec_val_next = (ub.inf && ua.sign != ub.sign) ? QNAN : a;
        end
        else if (ub.inf)
        begin
            spec_val_next = b;
        end
        else if (ua.zero && ub.zero)
        begin
            spec_val_next = {ua.sign & ub.sign, 31'd0};
        end
        else if (ua.zero)
        begin
            spec_val_next = b;
        end
        else if (ub.zero)
        begin
            spec_val_next = a;
        end
        else
        begin
            spec_next = 1'b0;
        end
    end

    // Alignment with sticky, then the add or subtract. The top bit is kept
    // free so that a carry out of the add stays in the word.
    always_comb
    begin
        d     = big_reg.exp - small_reg.exp;
        bigs  = {1'b0, big_reg.sig, 25'd0};
        smls  = {1'b0, small_reg.sig, 25'd0};
        st    = 1'b0;
        if (d >= 10'd50)
        begin
            smlsh = 50'd1;
        end
        else
        begin
            st    = |(smls & ((50'd1 << 6'(d)) - 50'd1));
            smlsh = (smls >> 6'(d)) | {49'd0, st};
        end
        if (big_reg.sign == small_reg.sign)
        begin
            sum = bigs + smlsh;
        end
        else
        begin
            sum = bigs - smlsh;
        end
    end

    always_comb
    begin
        if (spec2_reg)
        begin
            s_next = spec2_val_reg;
        end
        else if (cancel_reg)
        begin
            s_next = 32'd0;
        end
        else
        begin
            s_next = fp_round(raw_reg.sign, raw_reg.exp, raw_reg.sig);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big_reg       <= swap ? ub : ua;
            small_reg     <= swap ? ua : ub;
            spec_reg      <= spec_next;
            spec_val_reg  <= spec_val_next;
            spec2_reg     <= spec_reg;
            spec2_val_reg <= spec_val_reg;
            cancel_reg    <= (sum == 50'd0);
            raw_reg.nan   <= 1'b0;
            raw_reg.inf   <= 1'b0;
            raw_reg.zero  <= 1'b0;
            raw_reg.sign  <= big_reg.sign;
            raw_reg.exp   <= big_reg.exp - 10'd25;
            raw_reg.sig   <= sum;
            s_reg         <= s_next;
        end
    end

    assign s = s_reg;

endmodule

`default_nettype wire
